// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on the rising clock edge, switched off while the given reset is low.
`define WSD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same check on the block's own clock and reset.
`define WSD_ASSERT(lbl, prop, msg) \
  `WSD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define WSD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define WSD_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== src/wsd_pkg.sv =====
// Types and constants of the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  // Default width of the payload length counter.
  localparam int unsigned LEN_BITS_DEF = 64;

  // Frame opcodes.
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CLOSE    = 2'd1,
    ST_RESERVED = 2'd2
  } status_e;

  // One result item, with a flag saying whether the byte produced one.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       kind;
    logic       frame_last;
    status_e    status;
  } wsd_res_t;

endpackage
`default_nettype wire

// ===== src/wsd_parser.sv =====
// Frame header parser, unmasking and result generation for one byte per step.
`default_nettype none
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output wsd_res_t   res_o
);

  phase_e                 phase_q, phase_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   mask_on_q, mask_on_d;
  logic [2:0]             hcnt_q, hcnt_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             idx_q, idx_d;
  logic                   halted_q, halted_d;

  // Start-of-payload request and the frame-result request.
  logic                   beg_go;
  logic [LENGTH_BITS-1:0] beg_len;
  logic                   beg_ovf;
  logic [LENGTH_BITS-1:0] beg_sat;
  logic                   fb_go;
  logic                   fb_has;
  logic [7:0]             fb_byte;
  logic                   fb_last;
  logic [7:0]             key_byte;
  logic [LENGTH_BITS-1:0] shifted;
  logic                   pay_last;

  // Length shift register for the extended length bytes.
  assign shifted = {len_q[LENGTH_BITS-9:0], byte_i};

  // Current key byte, first received key byte for index zero.
  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!mask_on_q) begin
      key_byte = 8'h00;
    end
  end

  assign pay_last = (len_q[LENGTH_BITS-1:1] == '0);
  assign beg_sat  = beg_ovf ? {LENGTH_BITS{1'b1}} : beg_len;

  // Next state and result for the byte at the input register.
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    mask_on_d = mask_on_q;
    hcnt_d   = hcnt_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    key_d    = key_q;
    idx_d    = idx_q;
    halted_d = halted_q;
    beg_go   = 1'b0;
    beg_len  = len_q;
    beg_ovf  = ovf_q;
    fb_go    = 1'b0;
    fb_has   = 1'b0;
    fb_byte  = 8'h00;
    fb_last  = 1'b0;
    res_o    = '0;

    if (!halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_on_d = byte_i[7];
          hcnt_d    = 3'd0;
          key_d     = '0;
          len_d     = '0;
          ovf_d     = 1'b0;
          if (byte_i[6:0] == LEN7_EXT16) begin
            phase_d = PH_EXT16;
          end else if (byte_i[6:0] == LEN7_EXT64) begin
            phase_d = PH_EXT64;
          end else begin
            len_d = LENGTH_BITS'(byte_i[6:0]);
            if (byte_i[7]) begin
              phase_d = PH_MASK;
            end else begin
              beg_go  = 1'b1;
              beg_len = LENGTH_BITS'(byte_i[6:0]);
              beg_ovf = 1'b0;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_d = shifted;
          ovf_d = ovf_q | (len_q[LENGTH_BITS-1:LENGTH_BITS-8] != 8'h00);
          if (hcnt_q == ((phase_q == PH_EXT16) ? 3'd1 : 3'd7)) begin
            hcnt_d = 3'd0;
            if (mask_on_q) begin
              phase_d = PH_MASK;
            end else begin
              beg_go  = 1'b1;
              beg_len = shifted;
              beg_ovf = ovf_d;
            end
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          if (hcnt_q == 3'd3) begin
            beg_go = 1'b1;
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          idx_d   = idx_q + 2'd1;
          len_d   = pay_last ? '0 : len_q - LENGTH_BITS'(1);
          if (pay_last) begin
            phase_d = PH_HDR0;
          end
          fb_go   = 1'b1;
          fb_has  = 1'b1;
          fb_byte = byte_i ^ key_byte;
          fb_last = pay_last;
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Start of the payload: saturate the length, empty frames end here.
      if (beg_go) begin
        len_d = beg_sat;
        ovf_d = 1'b0;
        idx_d = 2'd0;
        if (beg_sat == '0) begin
          phase_d = PH_HDR0;
          fb_go   = 1'b1;
          fb_last = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end

      // Result selection by frame opcode.
      if (fb_go) begin
        case (opcode_q)
          OP_CONT, OP_BIN: begin
            if (fb_has) begin
              res_o.valid      = 1'b1;
              res_o.data_byte  = fb_byte;
              res_o.has_byte   = 1'b1;
              res_o.frame_last = fb_last;
            end
          end
          OP_PING: begin
            res_o.valid      = 1'b1;
            res_o.kind       = 1'b1;
            res_o.has_byte   = fb_has;
            res_o.data_byte  = fb_has ? fb_byte : 8'h00;
            res_o.frame_last = fb_has ? fb_last : 1'b1;
          end
          OP_TEXT, OP_PONG: begin
            res_o.valid = 1'b0;
          end
          default: begin
            if (fb_last) begin
              res_o.valid      = 1'b1;
              res_o.frame_last = 1'b1;
              res_o.status     = (opcode_q == OP_CLOSE) ? ST_CLOSE : ST_RESERVED;
              halted_d         = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Parser state, updated once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= '0;
      mask_on_q <= 1'b0;
      hcnt_q    <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      key_q     <= '0;
      idx_q     <= '0;
      halted_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_on_q <= mask_on_d;
      hcnt_q    <= hcnt_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      halted_q  <= halted_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
// Channel   Direction  Item                     Payload
// s_axis    in         one received byte        tdata[7:0] rx_byte
// m_axis    out        one result               tdata data_byte, status; tuser; tlast
//
// One byte is accepted every cycle when the result side keeps up.
// A result goes from the input register through the parser into the result register before m_axis shows it.
// Bytes that give no result clear the result valid flag but load no data into the result register.
// A stall on m_axis holds the result register; one more byte waits in the input register.
// Reset is asynchronous and active low; after a close or reserved opcode the block stays idle.
`default_nettype none
`include "assert_macros.svh"
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] kind
  output logic        m_axis_tlast    // frame_last
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       adv;
  wsd_res_t   res;
  logic       out_vld_q;
  wsd_res_t   out_q;
  logic       out_hs;
  logic       out_err;
  logic       out_nobyte;

  // The parser consumes the held byte once the result register can take a result.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res.valid;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b000000, 2'(out_q.status), out_q.data_byte};
  assign m_axis_tuser  = {out_q.kind, out_q.has_byte};
  assign m_axis_tlast  = out_q.frame_last;

  // Shorthands for the output checks below.
  assign out_hs     = m_axis_tvalid && m_axis_tready;
  assign out_err    = m_axis_tvalid && (m_axis_tdata[9:8] != ST_OK);
  assign out_nobyte = m_axis_tvalid && !m_axis_tuser[0];

  // An error result ends its frame and carries no byte.
  `WSD_ASSERT(a_err_last, out_err |-> m_axis_tlast && !m_axis_tuser[0], "error not at frame end")
  // Once an error result has been taken, nothing more comes out.
  `WSD_ASSERT(a_halt_quiet, out_hs && out_err |=> !m_axis_tvalid, "result after halt")
  // A byteless result is always the last of its frame.
  `WSD_ASSERT(a_marker_last, out_nobyte |-> m_axis_tlast, "byteless result not at frame end")
  // A byteless result carries a zero data byte.
  `WSD_ASSERT(a_marker_zero, out_nobyte |-> (m_axis_tdata[7:0] == 8'h00), "stray data byte")

endmodule
`default_nettype wire
